// File: rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared widths, codes and the request token that moves along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IP_W          = 32;
    localparam int MAC_W         = 48;
    localparam int ACT_W         = 2;
    localparam int STATUS_W      = 3;

    // request actions
    localparam logic [ACT_W-1:0] ACT_LEARN      = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP_IP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOOKUP_MAC = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HIT     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISS    = 3'd4;

    // request in flight, with what it has collected so far
    typedef struct packed {
        logic             valid;
        logic [ACT_W-1:0] action;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic             hit;
        logic             added;
        logic [IP_W-1:0]  ip_res;
        logic [MAC_W-1:0] mac_res;
    } tok_t;

endpackage

`default_nettype wire

// File: rtl/arpc_if.sv
// ----------------------------------------------------------------------------
// arpc_if
// Valid/ready channels for table requests and table results.
// ----------------------------------------------------------------------------
`default_nettype none

interface arpc_req_if;
    logic                         valid;
    logic                         ready;
    logic [arpc_pkg::ACT_W-1:0]   action;
    logic [arpc_pkg::IP_W-1:0]    ip_address;
    logic [arpc_pkg::MAC_W-1:0]   mac_address;

    modport source (output valid, output action, output ip_address, output mac_address,
                    input ready);
    modport sink   (input valid, input action, input ip_address, input mac_address,
                    output ready);
endinterface

interface arpc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [arpc_pkg::IP_W-1:0]     ip_result;
    logic [arpc_pkg::MAC_W-1:0]    mac_result;
    logic [arpc_pkg::STATUS_W-1:0] status;

    modport source (output valid, output found, output ip_result, output mac_result,
                    output status, input ready);
    modport sink   (input valid, input found, input ip_result, input mac_result,
                    input status, output ready);
endinterface

`default_nettype wire

// File: rtl/arpc_cell.sv
// ----------------------------------------------------------------------------
// arpc_cell
// One table entry: compares the passing request with its IP and MAC, learns
// or answers, and hands the token on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire arpc_pkg::tok_t tok_in,
    output arpc_pkg::tok_t      tok_out
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [arpc_pkg::IP_W-1:0]  ip_reg;
    logic [arpc_pkg::IP_W-1:0]  ip_next;
    logic [arpc_pkg::MAC_W-1:0] mac_reg;
    logic [arpc_pkg::MAC_W-1:0] mac_next;
    arpc_pkg::tok_t             tok_reg;
    arpc_pkg::tok_t             tok_next;
    logic                       ip_match;
    logic                       mac_match;

    assign ip_match  = valid_reg && (ip_reg == tok_in.ip);
    assign mac_match = valid_reg && (mac_reg == tok_in.mac);

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        ip_next    = ip_reg;
        mac_next   = mac_reg;
        if (tok_in.valid)
        begin
            case (tok_in.action)
                arpc_pkg::ACT_LEARN:
                begin
                    if (!tok_in.hit && ip_match)
                    begin
                        mac_next     = tok_in.mac;
                        tok_next.hit = 1'b1;
                    end
                    else if (!tok_in.hit && !valid_reg)
                    begin
                        // valid entries are contiguous: first free one means no match
                        valid_next     = 1'b1;
                        ip_next        = tok_in.ip;
                        mac_next       = tok_in.mac;
                        tok_next.hit   = 1'b1;
                        tok_next.added = 1'b1;
                    end
                end
                arpc_pkg::ACT_LOOKUP_IP:
                begin
                    if (!tok_in.hit && ip_match)
                    begin
                        tok_next.hit     = 1'b1;
                        tok_next.mac_res = mac_reg;
                    end
                end
                arpc_pkg::ACT_LOOKUP_MAC:
                begin
                    // later cells are newer: overwrite with every match
                    if (mac_match)
                    begin
                        tok_next.hit    = 1'b1;
                        tok_next.ip_res = ip_reg;
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ip_reg  <= ip_next;
            mac_reg <= mac_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// File: rtl/arp_cache_table.sv
// ----------------------------------------------------------------------------
// arp_cache_table
// IP-to-MAC table without aging, built as a chain of entry cells.
// ----------------------------------------------------------------------------
// A request enters the first cell on acceptance and moves one cell per cycle
// (unless the chain is held) down a chain of TABLE_ENTRIES cells, oldest entry
// first; each cell compares, learns or answers as the token passes. After the
// last cell the result goes into the output register, and the next request is
// accepted at the following edge, so no new request is taken until the last one
// has run the whole cell chain. A result still waiting in the output register when
// the next token reaches the last cell holds the chain until it is taken. One
// request is in the chain at a time. Reset clears all entry valid bits at
// once, so the table is usable right away.
`default_nettype none

module arp_cache_table (
    input  wire logic  clk,
    input  wire logic  rst_n,
    arpc_req_if.sink   req,
    arpc_rsp_if.source rsp
);

    localparam int LAST = arpc_pkg::TABLE_ENTRIES - 1;

    arpc_pkg::tok_t                tok_in;
    arpc_pkg::tok_t                tok [arpc_pkg::TABLE_ENTRIES];
    logic [arpc_pkg::TABLE_ENTRIES-1:0] tok_valid;
    logic                          adv;
    logic                          load;
    logic                          accept;
    logic                          inflight_reg;
    logic                          inflight_next;
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    logic                          found_reg;
    logic                          found_next;
    logic [arpc_pkg::IP_W-1:0]     ip_res_reg;
    logic [arpc_pkg::IP_W-1:0]     ip_res_next;
    logic [arpc_pkg::MAC_W-1:0]    mac_res_reg;
    logic [arpc_pkg::MAC_W-1:0]    mac_res_next;
    logic [arpc_pkg::STATUS_W-1:0] status_reg;
    logic [arpc_pkg::STATUS_W-1:0] status_next;

    assign req.ready = !inflight_reg;
    assign accept    = req.valid && !inflight_reg;

    // hold the chain while a finished token waits on a full output register
    assign adv  = !(tok[LAST].valid && rsp_valid_reg && !rsp.ready);
    assign load = tok[LAST].valid && adv;

    always_comb
    begin
        tok_in         = '0;
        tok_in.valid   = accept;
        tok_in.action  = req.action;
        tok_in.ip      = req.ip_address;
        tok_in.mac     = req.mac_address;
    end

    genvar gi;
    generate
        for (gi = 0; gi < arpc_pkg::TABLE_ENTRIES; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                arpc_cell u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .adv     (adv),
                    .tok_in  (tok_in),
                    .tok_out (tok[gi])
                );
            end
            else
            begin : g_rest
                arpc_cell u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .adv     (adv),
                    .tok_in  (tok[gi-1]),
                    .tok_out (tok[gi])
                );
            end
            assign tok_valid[gi] = tok[gi].valid;
        end
    endgenerate

    // result formatting from the token leaving the chain
    always_comb
    begin
        found_next   = 1'b0;
        ip_res_next  = '0;
        mac_res_next = '0;
        status_next  = arpc_pkg::ST_MISS;
        case (tok[LAST].action)
            arpc_pkg::ACT_LEARN:
            begin
                if (!tok[LAST].hit)
                    status_next = arpc_pkg::ST_FULL;
                else if (tok[LAST].added)
                    status_next = arpc_pkg::ST_ADDED;
                else
                    status_next = arpc_pkg::ST_UPDATED;
            end
            arpc_pkg::ACT_LOOKUP_IP:
            begin
                found_next   = tok[LAST].hit;
                mac_res_next = tok[LAST].mac_res;
                status_next  = tok[LAST].hit ? arpc_pkg::ST_HIT : arpc_pkg::ST_MISS;
            end
            arpc_pkg::ACT_LOOKUP_MAC:
            begin
                found_next  = tok[LAST].hit;
                ip_res_next = tok[LAST].ip_res;
                status_next = tok[LAST].hit ? arpc_pkg::ST_HIT : arpc_pkg::ST_MISS;
            end
            default:
            begin
                status_next = arpc_pkg::ST_MISS;
            end
        endcase
    end

    always_comb
    begin
        inflight_next = inflight_reg;
        if (accept)
            inflight_next = 1'b1;
        else if (load)
            inflight_next = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (load)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            inflight_reg  <= inflight_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            found_reg   <= found_next;
            ip_res_reg  <= ip_res_next;
            mac_res_reg <= mac_res_next;
            status_reg  <= status_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.found      = found_reg;
    assign rsp.ip_result  = ip_res_reg;
    assign rsp.mac_result = mac_res_reg;
    assign rsp.status     = status_reg;

    // at most one token travels the chain
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tok_valid))
        else $error("more than one request token in the cell chain");

    // a token in the chain always belongs to an accepted request
    assert property (@(posedge clk) disable iff (!rst_n) (|tok_valid) |-> inflight_reg)
        else $error("token in chain without a request in flight");

    // an accepted beat lands in the first cell on the next edge
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> tok[0].valid)
        else $error("accepted request did not enter the first cell");

    // learn results never report found
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg == arpc_pkg::ST_UPDATED ||
                           status_reg == arpc_pkg::ST_ADDED ||
                           status_reg == arpc_pkg::ST_FULL)) |-> !found_reg)
        else $error("learn result with found set");

endmodule

`default_nettype wire

// File: dv/tb_arp_cache_table.sv
// ----------------------------------------------------------------------------
// tb_arp_cache_table
// Self-checking testbench for the IP-to-MAC table: learns, IP and MAC lookups.
// ----------------------------------------------------------------------------
// A queue of requests, directed first and then random, feeds a bursty driver.
// Each accepted request runs through a model of the table kept here, and the
// reply it predicts is queued. A monitor checks every reply beat, field by
// field, against the oldest prediction while the receiver stalls on a
// changing pattern and once holds off for a long stretch.
// ----------------------------------------------------------------------------

module tb_arp_cache_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [arpc_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 480;
    localparam int DRAIN_CYCLES  = 60;
    localparam int HOLD_AT_CYCLE = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_PRINTED   = 40;

    typedef struct packed {
        logic [arpc_pkg::ACT_W-1:0] act;
        logic [arpc_pkg::IP_W-1:0]  ip;
        logic [arpc_pkg::MAC_W-1:0] mac;
        logic                       wait_idle;
    } lookup_req_t;

    typedef struct packed {
        logic                          found;
        logic [arpc_pkg::IP_W-1:0]     ip_result;
        logic [arpc_pkg::MAC_W-1:0]    mac_result;
        logic [arpc_pkg::STATUS_W-1:0] status;
    } table_reply_t;

    logic clk;
    logic rst_n;

    arpc_req_if req_ch ();
    arpc_rsp_if rsp_ch ();

    arp_cache_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // model of the table, entries in insertion order
    logic [arpc_pkg::IP_W-1:0]  tbl_ip  [arpc_pkg::TABLE_ENTRIES];
    logic [arpc_pkg::MAC_W-1:0] tbl_mac [arpc_pkg::TABLE_ENTRIES];
    int                         tbl_count = 0;

    lookup_req_t  pending_req_q [$];
    table_reply_t reply_q [$];

    int error_count = 0;
    int beats_in    = 0;
    int beats_out   = 0;
    int status_seen [5] = '{default: 0};

    int burst_left = 1;
    int gap_left   = 0;

    int ready_cycle = 0;
    int ready_mode  = 0;
    int hold_left   = 0;

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
            $display("MISMATCH at %0t ns, reply %0d: %s", $time, beats_out, msg);
        error_count++;
    endtask

    task automatic queue_req(input logic [arpc_pkg::ACT_W-1:0] act,
                             input logic [arpc_pkg::IP_W-1:0] ip,
                             input logic [arpc_pkg::MAC_W-1:0] mac, input logic wait_idle);
        lookup_req_t r;
        r.act       = act;
        r.ip        = ip;
        r.mac       = mac;
        r.wait_idle = wait_idle;
        pending_req_q.push_back(r);
    endtask

    // Apply one request to the table model and return the reply it must produce.
    function automatic table_reply_t predict_reply(input logic [arpc_pkg::ACT_W-1:0] act,
                                                   input logic [arpc_pkg::IP_W-1:0] ip,
                                                   input logic [arpc_pkg::MAC_W-1:0] mac);
        table_reply_t r;
        int slot;
        r.found      = 1'b0;
        r.ip_result  = '0;
        r.mac_result = '0;
        r.status     = arpc_pkg::ST_MISS;
        slot         = -1;
        case (act)
            arpc_pkg::ACT_LEARN:
            begin
                for (int i = 0; i < tbl_count; i++)
                    if (slot < 0 && tbl_ip[i] == ip) slot = i;
                if (slot >= 0)
                begin
                    tbl_mac[slot] = mac;
                    r.status      = arpc_pkg::ST_UPDATED;
                end
                else if (tbl_count < arpc_pkg::TABLE_ENTRIES)
                begin
                    tbl_ip[tbl_count]  = ip;
                    tbl_mac[tbl_count] = mac;
                    tbl_count++;
                    r.status = arpc_pkg::ST_ADDED;
                end
                else
                    r.status = arpc_pkg::ST_FULL;
            end
            arpc_pkg::ACT_LOOKUP_IP:
            begin
                for (int i = 0; i < tbl_count; i++)
                    if (slot < 0 && tbl_ip[i] == ip) slot = i;
                if (slot >= 0)
                begin
                    r.found      = 1'b1;
                    r.mac_result = tbl_mac[slot];
                    r.status     = arpc_pkg::ST_HIT;
                end
            end
            arpc_pkg::ACT_LOOKUP_MAC:
            begin
                // newest match wins: scan from the top down
                for (int i = tbl_count - 1; i >= 0; i--)
                    if (slot < 0 && tbl_mac[i] == mac) slot = i;
                if (slot >= 0)
                begin
                    r.found     = 1'b1;
                    r.ip_result = tbl_ip[slot];
                    r.status    = arpc_pkg::ST_HIT;
                end
            end
            default: ;
        endcase
        status_seen[r.status]++;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("timeout: %0d requests sent, %0d replies seen", beats_in, beats_out);
        $display("tb_arp_cache_table: FAIL");
        $finish;
    end

    // Driver: bursts of random length with random gaps; hold a beat until taken.
    always @(posedge clk)
    begin
        lookup_req_t nxt;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                reply_q.push_back(predict_reply(req_ch.action, req_ch.ip_address,
                                                req_ch.mac_address));
                beats_in++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left > 0 || pending_req_q.size() == 0 ||
                    (pending_req_q[0].wait_idle && reply_q.size() != 0))
                begin
                    if (gap_left > 0) gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    nxt = pending_req_q.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.action      <= nxt.act;
                    req_ch.ip_address  <= nxt.ip;
                    req_ch.mac_address <= nxt.mac;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
            end
        end
    end

    // Receiver: switch stall pattern now and then, with one long hold-off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            ready_cycle++;
            if (ready_cycle == HOLD_AT_CYCLE) hold_left = HOLD_CYCLES;
            if (ready_cycle % 150 == 0) ready_mode = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (ready_mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
                    2:       rsp_ch.ready <= ($urandom_range(0, 9) < 2);
                    default: rsp_ch.ready <= ready_cycle[2];
                endcase
            end
        end
    end

    // Monitor: compare each reply beat with the oldest prediction.
    always @(posedge clk)
    begin
        table_reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            beats_out++;
            if (reply_q.size() == 0)
                report_mismatch("reply with no request outstanding");
            else
            begin
                want = reply_q.pop_front();
                if (rsp_ch.found !== want.found)
                    report_mismatch($sformatf("found %b, want %b", rsp_ch.found, want.found));
                if (rsp_ch.ip_result !== want.ip_result)
                    report_mismatch($sformatf("ip_result %h, want %h",
                                              rsp_ch.ip_result, want.ip_result));
                if (rsp_ch.mac_result !== want.mac_result)
                    report_mismatch($sformatf("mac_result %h, want %h",
                                              rsp_ch.mac_result, want.mac_result));
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              rsp_ch.status, want.status));
            end
        end
    end

    initial
    begin
        logic [arpc_pkg::IP_W-1:0]  known_ip  [$];
        logic [arpc_pkg::MAC_W-1:0] known_mac [$];
        logic [arpc_pkg::IP_W-1:0]  ip;
        logic [arpc_pkg::MAC_W-1:0] mac;
        logic [31:0]                r_hi;
        logic [31:0]                r_lo;
        logic [31:0]                r_ip;
        logic                       sync;
        int                         pick;

        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.action      = arpc_pkg::ACT_LEARN;
        req_ch.ip_address  = '0;
        req_ch.mac_address = '0;
        rsp_ch.ready       = 1'b0;

        // empty table: both lookups and the unused action miss
        queue_req(arpc_pkg::ACT_LOOKUP_IP,  32'h0000_0000, 48'h0000_0000_0000, 1'b0);
        queue_req(arpc_pkg::ACT_LOOKUP_MAC, 32'h0000_0000, 48'h0000_0000_0000, 1'b0);
        queue_req(ACT_UNUSED,               32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
        // extremes of both fields
        queue_req(arpc_pkg::ACT_LEARN,      32'h0000_0000, 48'h0000_0000_0000, 1'b0);
        queue_req(arpc_pkg::ACT_LEARN,      32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_req(arpc_pkg::ACT_LOOKUP_IP,  32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_req(arpc_pkg::ACT_LOOKUP_IP,  32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b0);
        queue_req(arpc_pkg::ACT_LOOKUP_MAC, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
        // update in place; two entries now share MAC zero, newest must answer
        queue_req(arpc_pkg::ACT_LEARN,      32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b0);
        queue_req(arpc_pkg::ACT_LOOKUP_MAC, 32'h1234_5678, 48'h0000_0000_0000, 1'b0);
        queue_req(arpc_pkg::ACT_LEARN,      32'h0000_0000, 48'h1234_5678_9ABC, 1'b0);
        queue_req(arpc_pkg::ACT_LOOKUP_MAC, 32'h0000_0000, 48'h0000_0000_0000, 1'b0);
        queue_req(arpc_pkg::ACT_LOOKUP_MAC, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_req(arpc_pkg::ACT_LOOKUP_IP,  32'h0A00_0001, 48'h0000_0000_0000, 1'b0);
        queue_req(ACT_UNUSED,               32'h0000_0000, 48'h0000_0000_0000, 1'b0);
        queue_req(arpc_pkg::ACT_LEARN,      32'hAAAA_AAAA, 48'h5555_5555_5555, 1'b0);
        queue_req(arpc_pkg::ACT_LEARN,      32'h5555_5555, 48'hAAAA_AAAA_AAAA, 1'b0);
        queue_req(arpc_pkg::ACT_LOOKUP_MAC, 32'hFFFF_FFFF, 48'hAAAA_AAAA_AAAA, 1'b0);
        queue_req(arpc_pkg::ACT_LOOKUP_IP,  32'hAAAA_AAAA, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_req(arpc_pkg::ACT_LOOKUP_IP,  32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b0);

        known_ip  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
        known_mac = '{48'h0000_0000_0000, 48'h1234_5678_9ABC,
                      48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA};

        // Random part: new IPs are rare so the table fills gradually, then
        // stays full and new learns are dropped.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            r_hi = $urandom;
            r_lo = $urandom;
            r_ip = $urandom;
            mac  = {r_hi[15:0], r_lo};
            ip   = r_ip;
            // pause twice until the table has answered everything
            sync = (n == 0 || n == RANDOM_ITEMS / 2);
            if (pick < 40)
            begin
                if ($urandom_range(0, 99) < 15)
                    known_ip.push_back(ip);
                else
                    ip = known_ip[$urandom_range(0, known_ip.size() - 1)];
                if ($urandom_range(0, 1) == 0)
                    mac = known_mac[$urandom_range(0, known_mac.size() - 1)];
                else
                    known_mac.push_back(mac);
                queue_req(arpc_pkg::ACT_LEARN, ip, mac, sync);
            end
            else if (pick < 68)
            begin
                if ($urandom_range(0, 3) != 0)
                    ip = known_ip[$urandom_range(0, known_ip.size() - 1)];
                queue_req(arpc_pkg::ACT_LOOKUP_IP, ip, mac, sync);
            end
            else if (pick < 95)
            begin
                if ($urandom_range(0, 3) != 0)
                    mac = known_mac[$urandom_range(0, known_mac.size() - 1)];
                queue_req(arpc_pkg::ACT_LOOKUP_MAC, ip, mac, sync);
            end
            else
                queue_req(ACT_UNUSED, ip, mac, sync);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_req_q.size() != 0 || req_ch.valid || reply_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (reply_q.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", reply_q.size()));

        $display("covered %0d requests, %0d replies: %0d added, %0d updated, %0d dropped full",
                 beats_in, beats_out, status_seen[arpc_pkg::ST_ADDED],
                 status_seen[arpc_pkg::ST_UPDATED], status_seen[arpc_pkg::ST_FULL]);
        $display("lookups: %0d hits, %0d misses; %0d mismatches",
                 status_seen[arpc_pkg::ST_HIT], status_seen[arpc_pkg::ST_MISS], error_count);
        if (error_count == 0)
            $display("tb_arp_cache_table: PASS");
        else
            $display("tb_arp_cache_table: FAIL");
        $finish;
    end

endmodule
